FILE: hw/rtl/brs_pkg.sv
`default_nettype none
package brs_pkg;
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_REGION = 2'd1;
  localparam logic [1:0] MODE_COLUMN = 2'd2;

  localparam logic [1:0] KIND_ROW = 2'd0;
  localparam logic [1:0] KIND_REGION = 2'd1;
  localparam logic [1:0] KIND_COLUMN = 2'd2;

  localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WINDOW_LEFT = 3'd2;
  localparam logic [2:0] REG_WINDOW_TOP = 3'd3;
  localparam logic [2:0] REG_WINDOW_WIDTH = 3'd4;
  localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd5;
  localparam logic [2:0] REG_CLIP_THRESHOLD = 3'd6;

  localparam int DIV_N = 41;
  localparam int DIV_D = 25;

  typedef struct packed {
    logic [1:0] kind;
    logic [11:0] index;
    logic [15:0] minimum;
    logic [15:0] maximum;
    logic [15:0] mean;
    logic [24:0] count;
    logic [15:0] clip_fraction;
  } result_t;
endpackage
`default_nettype wire

FILE: hw/rtl/brs_div.sv
`default_nettype none
module brs_div
  import brs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [DIV_N-1:0] numer,
  input  wire logic [DIV_D-1:0] denom,
  output logic busy,
  output logic done,
  output logic [DIV_N-1:0] quot
);
  localparam int CW = $clog2(DIV_N + 1);
  logic [CW-1:0] cnt_r;
  logic busy_r;
  logic done_r;
  logic [DIV_N-1:0] q_r;
  logic [DIV_D:0] rem_r;
  logic [DIV_D-1:0] d_r;
  logic [DIV_D:0] shifted;
  logic [DIV_D:0] diff;

  assign shifted = {rem_r[DIV_D-1:0], q_r[DIV_N-1]};
  assign diff = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CW'(DIV_N);
        q_r <= numer;
        rem_r <= '0;
        d_r <= denom;
      end else if (busy_r) begin
        if (!diff[DIV_D]) begin
          rem_r <= diff;
          q_r <= {q_r[DIV_N-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r <= {q_r[DIV_N-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

FILE: hw/rtl/bayer_region_statistics.sv
// Raw Bayer region statistics.
// The in_ channel carries items: mode 0 is one pixel of a full frame in raster
// order, mode 1 reads the statistics of one region, mode 2 reads one column
// mean. The out_ channel returns row means at the end of each active row and
// one result for every read. Configuration is written through cfg_; the user
// must write it only while idle, as the block itself does not enforce this.
// A pixel in the window reads the column sum memory when it is accepted and
// writes back the updated sum in the ST_PIX state. Each row end and each
// non-empty read then runs the shared restoring divider before the result is
// registered: one division for a row or column mean, one or two for a region
// read (region mean and clip fraction). An empty read is answered straight
// from the idle state, without the divider.
// The input is held off while an item is in work or a result waits unaccepted.
// A stalled receiver therefore stalls the input after the one waiting result.
// Reset restores the register defaults and marks the frame as finished, so the
// first pixel clears all accumulators; the column memory is not cleared.
// Mode 3 items are taken and dropped.
`default_nettype none
module bayer_region_statistics
  import brs_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  input  wire logic [31:0] in_tdata,  // sample[15:0], read_index[27:16], zeros
  input  wire logic [1:0] in_tuser,   // mode
  output logic out_tvalid,
  input  wire logic out_tready,
  // index[11:0], minimum[27:12], maximum[43:28], mean[59:44], count[84:60],
  // clip_fraction[100:85], zeros
  output logic [103:0] out_tdata,
  output logic [1:0] out_tuser,       // kind
  input  wire logic cfg_wr_en,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int CAW = $clog2(MAX_WIDTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PIX = 3'd1;
  localparam logic [2:0] ST_DIV1 = 3'd2;
  localparam logic [2:0] ST_DIV2 = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;
  localparam logic [2:0] ST_CLIPW = 3'd5;

  logic [12:0] fw_r, fh_r, ww_r, wh_r;
  logic [11:0] wl_r, wt_r;
  logic [15:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 13'd4096; fh_r <= 13'd4096; wl_r <= '0; wt_r <= '0;
      ww_r <= 13'd4096; wh_r <= 13'd4096; thr_r <= 16'd65470;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH: fw_r <= cfg_data[12:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_data[12:0];
        REG_WINDOW_LEFT: wl_r <= cfg_data[11:0];
        REG_WINDOW_TOP: wt_r <= cfg_data[11:0];
        REG_WINDOW_WIDTH: ww_r <= cfg_data[12:0];
        REG_WINDOW_HEIGHT: wh_r <= cfg_data[12:0];
        REG_CLIP_THRESHOLD: thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [14:0] eff_w, eff_h, right, bottom, cols, rows;
  always_comb begin
    eff_w = (fw_r == '0) ? 15'd1 : (15'(fw_r) > 15'(MAX_WIDTH) ? 15'(MAX_WIDTH) : 15'(fw_r));
    eff_h = (fh_r == '0) ? 15'd1 :
        (15'(fh_r) > 15'(MAX_HEIGHT) ? 15'(MAX_HEIGHT) : 15'(fh_r));
    right = (15'(wl_r) + 15'(ww_r) > eff_w) ? eff_w : 15'(wl_r) + 15'(ww_r);
    bottom = (15'(wt_r) + 15'(wh_r) > eff_h) ? eff_h : 15'(wt_r) + 15'(wh_r);
    cols = (right > 15'(wl_r)) ? right - 15'(wl_r) : '0;
    rows = (bottom > 15'(wt_r)) ? bottom - 15'(wt_r) : '0;
  end

  logic [2:0] st_r;
  logic [14:0] rowp_r, colp_r;
  logic ff_r;
  logic [27:0] row_sum_r;
  logic [27:0] colmem [MAX_WIDTH];
  logic [27:0] col_rd_r;
  logic [CAW-1:0] col_wa_r;
  logic [27:0] col_wd_r;
  logic col_first_r;
  logic [15:0] smp_r;
  logic [15:0] rmin_r [5];
  logic [15:0] rmax_r [5];
  logic [39:0] rsum_r [5];
  logic [24:0] rcnt_r [5];
  logic [24:0] pcnt_r [4];
  logic [24:0] pclip_r [4];
  result_t res_r;
  logic outv_r;
  logic [1:0] pend_kind_r;
  logic [11:0] pend_idx_r;
  logic [2:0] ri_r;
  logic need_clip_r;
  logic [24:0] clip_den_r;

  logic div_start, div_busy, div_done;
  logic [DIV_N-1:0] div_num, div_q;
  logic [DIV_D-1:0] div_den;

  brs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .numer(div_num), .denom(div_den),
    .busy(div_busy), .done(div_done), .quot(div_q)
  );

  logic in_acc;
  assign in_tready = (st_r == ST_IDLE) && !outv_r;
  assign in_acc = in_tvalid && in_tready;

  logic [15:0] s_in;
  logic [11:0] ri_in;
  assign s_in = 16'(in_tdata[15:0] & 16'((17'd1 << SAMPLE_BITS) - 17'd1));
  assign ri_in = in_tdata[27:16];

  logic [14:0] row_c, col_c, ar, ac;
  logic act;
  logic [2:0] site, par;
  always_comb begin
    col_c = colp_r;
    row_c = rowp_r;
    if (col_c >= eff_w) begin
      col_c = '0;
      row_c = rowp_r + 1'b1;
    end
    if (row_c >= eff_h) row_c = '0;
    act = row_c >= 15'(wt_r) && row_c < bottom && col_c >= 15'(wl_r) && col_c < right;
    ar = row_c - 15'(wt_r);
    ac = col_c - 15'(wl_r);
    site = 3'd1 + {1'b0, ar[0], ac[0]};
    par = {1'b0, row_c[0], col_c[0]};
  end

  logic [27:0] rs_new;
  assign rs_new = (ff_r ? 28'd0 : row_sum_r) + 28'(s_in);

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == MODE_PIXEL && act) col_rd_r <= colmem[ac[CAW-1:0]];
    else if (in_acc && in_tuser == MODE_COLUMN) col_rd_r <= colmem[ri_in[CAW-1:0]];
    if (st_r == ST_PIX) colmem[col_wa_r] <= col_first_r ? col_wd_r : col_rd_r + col_wd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      rowp_r <= '0;
      colp_r <= '0;
      ff_r <= 1'b1;
      row_sum_r <= '0;
      outv_r <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        rmin_r[i] <= '1; rmax_r[i] <= '0; rsum_r[i] <= '0; rcnt_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        pcnt_r[i] <= '0; pclip_r[i] <= '0;
      end
    end else begin
      if (outv_r && out_tready) outv_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_tuser)
              MODE_PIXEL: begin
                if (ff_r) begin
                  for (int i = 0; i < 5; i++) begin
                    rmin_r[i] <= '1; rmax_r[i] <= '0; rsum_r[i] <= '0; rcnt_r[i] <= '0;
                  end
                  for (int i = 0; i < 4; i++) begin
                    pcnt_r[i] <= '0; pclip_r[i] <= '0;
                  end
                end
                ff_r <= 1'b0;
                if (act) begin
                  for (int i = 0; i < 5; i++) begin
                    if (i == 0 || 3'(i) == site) begin
                      if (ff_r || s_in < rmin_r[i]) rmin_r[i] <= s_in;
                      if (ff_r || s_in > rmax_r[i]) rmax_r[i] <= s_in;
                      rsum_r[i] <= (ff_r ? 40'd0 : rsum_r[i]) + 40'(s_in);
                      rcnt_r[i] <= (ff_r ? 25'd0 : rcnt_r[i]) + 25'd1;
                    end
                  end
                  for (int i = 0; i < 4; i++) begin
                    if (3'(i) == par) begin
                      pcnt_r[i] <= (ff_r ? 25'd0 : pcnt_r[i]) + 25'd1;
                      if (s_in >= thr_r) pclip_r[i] <= (ff_r ? 25'd0 : pclip_r[i]) + 25'd1;
                    end
                  end
                  col_wa_r <= ac[CAW-1:0];
                  col_wd_r <= 28'(s_in);
                  col_first_r <= (ar == '0);
                  st_r <= ST_PIX;
                  if (col_c + 1'b1 == right) begin
                    row_sum_r <= '0;
                    pend_kind_r <= KIND_ROW;
                    pend_idx_r <= ar[11:0];
                    div_num <= DIV_N'(rs_new);
                    div_den <= DIV_D'(ac + 1'b1);
                    need_clip_r <= 1'b0;
                  end else begin
                    row_sum_r <= rs_new;
                    div_den <= '0;
                  end
                end else if (ff_r) begin
                  row_sum_r <= '0;
                end
                colp_r <= col_c + 1'b1;
                rowp_r <= row_c;
                if (col_c + 1'b1 >= eff_w) begin
                  colp_r <= '0;
                  rowp_r <= row_c + 1'b1;
                  if (row_c + 1'b1 >= eff_h) begin
                    rowp_r <= '0;
                    ff_r <= 1'b1;
                  end
                end
              end
              MODE_REGION: begin
                pend_kind_r <= KIND_REGION;
                pend_idx_r <= ri_in;
                ri_r <= ri_in[2:0];
                if (ri_in > 12'd4 || rcnt_r[ri_in[2:0]] == '0) begin
                  res_r <= '{KIND_REGION, ri_in, 16'd0, 16'd0, 16'd0, 25'd0, 16'd0};
                  outv_r <= 1'b1;
                end else begin
                  div_num <= DIV_N'(rsum_r[ri_in[2:0]]);
                  div_den <= rcnt_r[ri_in[2:0]];
                  need_clip_r <= ri_in != '0 && pcnt_r[2'(ri_in[2:0] - 3'd1)] != '0;
                  clip_den_r <= pcnt_r[2'(ri_in[2:0] - 3'd1)];
                  st_r <= ST_DIV1;
                end
              end
              MODE_COLUMN: begin
                if (15'(ri_in) >= cols || rows == '0) begin
                  res_r <= '{KIND_COLUMN, ri_in, 16'd0, 16'd0, 16'd0, 25'd0, 16'd0};
                  outv_r <= 1'b1;
                end else begin
                  pend_kind_r <= KIND_COLUMN;
                  pend_idx_r <= ri_in;
                  div_den <= DIV_D'(rows);
                  need_clip_r <= 1'b0;
                  st_r <= ST_CLIPW;
                end
              end
              default: ;
            endcase
          end
        end
        ST_CLIPW: begin
          div_num <= DIV_N'(col_rd_r);
          st_r <= ST_DIV1;
        end
        ST_PIX: st_r <= (div_den != '0) ? ST_DIV1 : ST_IDLE;
        ST_DIV1: begin
          if (div_done) begin
            res_r.kind <= pend_kind_r;
            res_r.index <= pend_idx_r;
            res_r.mean <= div_q[15:0];
            res_r.count <= div_den;
            res_r.minimum <= (pend_kind_r == KIND_REGION) ? rmin_r[ri_r] : 16'd0;
            res_r.maximum <= (pend_kind_r == KIND_REGION) ? rmax_r[ri_r] : 16'd0;
            res_r.clip_fraction <= '0;
            if (need_clip_r) begin
              div_num <= {pclip_r[2'(ri_r - 3'd1)], 16'd0};
              div_den <= clip_den_r;
              st_r <= ST_DIV2;
            end else st_r <= ST_OUT;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            res_r.clip_fraction <= (div_q[DIV_N-1:16] != '0) ? 16'hFFFF : div_q[15:0];
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          outv_r <= 1'b1;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  logic go1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) go1_r <= 1'b0;
    else go1_r <= ((st_r == ST_PIX && div_den != '0) ||
                   (st_r == ST_IDLE && in_acc && in_tuser == MODE_REGION &&
                    !(ri_in > 12'd4 || rcnt_r[ri_in[2:0]] == '0)) ||
                   st_r == ST_CLIPW ||
                   (st_r == ST_DIV1 && div_done && need_clip_r));
  end
  assign div_start = go1_r && !div_busy;

  assign out_tvalid = outv_r;
  assign out_tuser = res_r.kind;
  assign out_tdata = {3'd0, res_r.clip_fraction, res_r.count, res_r.mean,
                      res_r.maximum, res_r.minimum, res_r.index};
endmodule
`default_nettype wire

FILE: bench/tb_bayer_region_statistics.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_bayer_region_statistics
  import brs_pkg::*;
();

  class brs_scoreboard;
    bit [12:0] frame_w, frame_h, win_w, win_h;
    bit [11:0] win_l, win_t;
    bit [15:0] clip_thr;

    int row_pos, col_pos;
    bit frame_done;
    bit [27:0] row_acc;
    bit [27:0] col_acc[4096];
    bit col_seen[4096];
    bit [15:0] reg_min[5], reg_max[5];
    bit [39:0] reg_sum[5];
    bit [24:0] reg_cnt[5];
    bit [24:0] par_cnt[4], par_clip[4];

    result_t pending[$];
    int errors, results_checked, items_noted, row_results;

    function new();
      frame_w = 4096; frame_h = 4096; win_l = 0; win_t = 0;
      win_w = 4096; win_h = 4096; clip_thr = 65470;
      row_pos = 0; col_pos = 0; frame_done = 1;
      clear_stats();
    endfunction

    function void clear_stats();
      for (int i = 0; i < 5; i++) begin
        reg_min[i] = '1; reg_max[i] = 0; reg_sum[i] = 0; reg_cnt[i] = 0;
      end
      for (int i = 0; i < 4; i++) begin
        par_cnt[i] = 0; par_clip[i] = 0;
      end
      row_acc = 0;
    endfunction

    function void write_reg(logic [2:0] idx, bit [15:0] val);
      case (idx)
        REG_FRAME_WIDTH: frame_w = val[12:0];
        REG_FRAME_HEIGHT: frame_h = val[12:0];
        REG_WINDOW_LEFT: win_l = val[11:0];
        REG_WINDOW_TOP: win_t = val[11:0];
        REG_WINDOW_WIDTH: win_w = val[12:0];
        REG_WINDOW_HEIGHT: win_h = val[12:0];
        REG_CLIP_THRESHOLD: clip_thr = val;
        default: ;
      endcase
    endfunction

    function int eff_w();
      return frame_w == 0 ? 1 : (frame_w > 4096 ? 4096 : int'(frame_w));
    endfunction

    function int eff_h();
      return frame_h == 0 ? 1 : (frame_h > 4096 ? 4096 : int'(frame_h));
    endfunction

    function int right_edge();
      int r;
      r = int'(win_l) + int'(win_w);
      return r > eff_w() ? eff_w() : r;
    endfunction

    function int bottom_edge();
      int b;
      b = int'(win_t) + int'(win_h);
      return b > eff_h() ? eff_h() : b;
    endfunction

    function int active_cols();
      return right_edge() > win_l ? right_edge() - int'(win_l) : 0;
    endfunction

    function int active_rows();
      return bottom_edge() > win_t ? bottom_edge() - int'(win_t) : 0;
    endfunction

    function void add_to(int r, bit [15:0] s);
      if (s < reg_min[r]) reg_min[r] = s;
      if (s > reg_max[r]) reg_max[r] = s;
      reg_sum[r] = reg_sum[r] + 40'(s);
      reg_cnt[r] = reg_cnt[r] + 25'd1;
    endfunction

    function void note_input(logic [1:0] mode, bit [15:0] s, bit [11:0] ri);
      result_t res;
      int w, h, rgt, bot, ar, ac, site, par, rows;
      bit [63:0] frac;
      w = eff_w(); h = eff_h(); rgt = right_edge(); bot = bottom_edge();
      res = '0;
      items_noted++;
      if (mode == MODE_PIXEL) begin
        if (frame_done) begin
          clear_stats();
          frame_done = 0;
        end
        if (col_pos >= w) begin
          col_pos = 0; row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        if (row_pos >= win_t && row_pos < bot && col_pos >= win_l && col_pos < rgt) begin
          ar = row_pos - int'(win_t); ac = col_pos - int'(win_l);
          site = ((ar & 1) << 1) | (ac & 1);
          par = ((row_pos & 1) << 1) | (col_pos & 1);
          add_to(0, s);
          add_to(1 + site, s);
          par_cnt[par]++;
          if (s >= clip_thr) par_clip[par]++;
          if (ar == 0) begin
            col_acc[ac] = 28'(s);
            col_seen[ac] = 1;
          end else begin
            col_acc[ac] = col_acc[ac] + 28'(s);
          end
          row_acc = row_acc + 28'(s);
          if (col_pos + 1 == rgt) begin
            res.kind = KIND_ROW; res.index = 12'(ar);
            res.mean = 16'(row_acc / (ac + 1)); res.count = 25'(ac + 1);
            row_acc = 0;
            pending.insert(pending.size(), res);
            row_results++;
          end
        end
        col_pos++;
        if (col_pos >= w) begin
          col_pos = 0; row_pos++;
          if (row_pos >= h) begin
            row_pos = 0; frame_done = 1;
          end
        end
      end else if (mode == MODE_REGION) begin
        res.kind = KIND_REGION; res.index = ri;
        if (ri <= 4 && reg_cnt[ri] != 0) begin
          res.minimum = reg_min[ri]; res.maximum = reg_max[ri];
          res.mean = 16'(reg_sum[ri] / reg_cnt[ri]); res.count = reg_cnt[ri];
          if (ri > 0 && par_cnt[ri - 1] != 0) begin
            frac = (64'(par_clip[ri - 1]) << 16) / par_cnt[ri - 1];
            res.clip_fraction = frac > 65535 ? 16'hFFFF : frac[15:0];
          end
        end
        pending.insert(pending.size(), res);
      end else if (mode == MODE_COLUMN) begin
        res.kind = KIND_COLUMN; res.index = ri;
        rows = active_rows();
        if (ri < active_cols() && rows != 0) begin
          res.mean = 16'(col_acc[ri] / rows); res.count = 25'(rows);
        end
        pending.insert(pending.size(), res);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [103:0] data);
      result_t got, want;
      got.kind = kind; got.index = data[11:0]; got.minimum = data[27:12];
      got.maximum = data[43:28]; got.mean = data[59:44]; got.count = data[84:60];
      got.clip_fraction = data[100:85];
      results_checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want || data[103:101] !== 3'b000) begin
        errors++;
        if (errors <= 10) $display("Mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  localparam logic [1:0] MODE_IGNORED = 2'd3;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [103:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_wr_en = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  brs_scoreboard stats = new();
  bit idling = 1;
  int stall_left = 0;

  always #2 clk = ~clk;

  bayer_region_statistics dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) stats.check_result(out_tuser, out_tdata);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left <= int'($urandom_range(1, 15)) - 1;
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  task automatic send_item(logic [1:0] mode, bit [15:0] s, bit [11:0] ri);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= {4'b0, ri, s};
    do @(posedge clk); while (!in_tready);
    stats.note_input(mode, s, ri);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (stats.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, bit [15:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    stats.write_reg(idx, val);
  endtask

  task automatic set_window(bit [15:0] fw, bit [15:0] fh, bit [15:0] wl, bit [15:0] wt,
                            bit [15:0] ww, bit [15:0] wh, bit [15:0] thr);
    drain();
    write_cfg(REG_FRAME_WIDTH, fw);
    write_cfg(REG_FRAME_HEIGHT, fh);
    write_cfg(REG_WINDOW_LEFT, wl);
    write_cfg(REG_WINDOW_TOP, wt);
    write_cfg(REG_WINDOW_WIDTH, ww);
    write_cfg(REG_WINDOW_HEIGHT, wh);
    write_cfg(REG_CLIP_THRESHOLD, thr);
    cfg_wr_en <= 0;
  endtask

  task automatic column_read();
    int cols, rows, tries;
    bit [11:0] ri;
    cols = stats.active_cols();
    rows = stats.active_rows();
    if ((rows == 0 || $urandom_range(0, 3) == 0) && cols < 4096) begin
      send_item(MODE_COLUMN, 16'($urandom), 12'($urandom_range(cols, 4095)));
      return;
    end
    for (tries = 0; tries < 40; tries++) begin
      ri = 12'($urandom_range(0, cols > 0 ? cols - 1 : 0));
      if (rows == 0 || cols == 0 || stats.col_seen[ri]) begin
        send_item(MODE_COLUMN, 16'($urandom), ri);
        return;
      end
    end
    send_item(MODE_PIXEL, 16'($urandom), 12'($urandom));
  endtask

  task automatic random_items(int n);
    int pick;
    bit [15:0] s;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      s = $urandom_range(0, 4) == 0 ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0) :
          16'($urandom);
      if (pick < 80) send_item(MODE_PIXEL, s, 12'($urandom));
      else if (pick < 88) send_item(MODE_REGION, 16'($urandom),
                                    $urandom_range(0, 5) == 0 ? 12'($urandom) :
                                    12'($urandom_range(0, 4)));
      else if (pick < 96) column_read();
      else send_item(MODE_IGNORED, 16'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    int fw, fh;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reads before any pixel see empty regions.
    for (int r = 0; r < 5; r++) send_item(MODE_REGION, 16'hFFFF, 12'(r));
    send_item(MODE_REGION, 16'h0, 12'hFFF);
    send_item(MODE_IGNORED, 16'hFFFF, 12'hFFF);
    send_item(MODE_PIXEL, 16'hFFFF, 12'hFFF);
    send_item(MODE_PIXEL, 16'h0, 12'h0);
    send_item(MODE_PIXEL, 16'hFFC0, 12'h0);
    send_item(MODE_COLUMN, 16'h0, 12'd1);
    for (int r = 0; r < 5; r++) send_item(MODE_REGION, 16'h0, 12'(r));

    set_window(8, 6, 1, 1, 5, 4, 60000);
    random_items(150);
    set_window(0, 0, 0, 0, 1, 1, 0);
    random_items(40);
    set_window(0, 0, 0, 0, 0, 0, 0);
    random_items(30);
    set_window(8191, 3, 4090, 0, 8191, 8191, 65535);
    random_items(250);
    set_window(4096, 4096, 4095, 4095, 4096, 4096, 100);
    random_items(20);
    set_window(12, 10, 10, 8, 7, 5, 30000);
    random_items(120);
    set_window(6, 5, 7, 0, 3, 3, 1);
    random_items(40);
    for (int p = 0; p < 8; p++) begin
      fw = $urandom_range(1, 16);
      fh = $urandom_range(1, 10);
      if (p == 6) idling = 0;
      set_window(16'(fw), 16'(fh), 16'($urandom_range(0, fw)), 16'($urandom_range(0, fh)),
                 16'($urandom_range(0, fw + 2)), 16'($urandom_range(0, fh + 2)),
                 16'($urandom));
      random_items(120);
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d items over 15 window settings with random stalls on both sides.",
             stats.items_noted);
    $display("Checked %0d results, %0d of them row means.", stats.results_checked,
             stats.row_results);
    if (stats.errors == 0 && stats.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", stats.errors,
               stats.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", stats.pending.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire

FILE: bayer_region_statistics.f
hw/rtl/brs_pkg.sv
hw/rtl/brs_div.sv
hw/rtl/bayer_region_statistics.sv
bench/tb_bayer_region_statistics.sv
